[hdl/arwat_pkg.sv]
`timescale 1ns / 1ps

package arwat_pkg;

  // item kinds
  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_LOAD_REG = 2'd1;
  localparam logic [1:0] KIND_LOAD_WIN = 2'd2;

  localparam int TAG_LSB   = 30;
  localparam int TAG_W     = 64 - TAG_LSB;
  localparam int BUS_W     = 20;
  localparam int NUM_BASES = 8;

  localparam logic [63:0] LOW_MASK = 64'h0000_0000_3FFF_FFFF;
  localparam logic [63:0] TAG_MASK = 64'hFFFF_FFFF_C000_0000;

  localparam logic [BUS_W-1:0] ACCEL_BASE [NUM_BASES] = '{
    20'hD0000, 20'hE0000, 20'hF0000, 20'h80000,
    20'h90000, 20'hA0000, 20'hB0000, 20'hC0000
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_REG,
    ST_SCAN_WIN,
    ST_EMIT_ONE,
    ST_EMIT_LO,
    ST_EMIT_HI
  } state_t;

  // table access strobes from the sequencer
  typedef struct packed {
    logic ld_reg;
    logic ld_win;
    logic rd_reg;
    logic rd_win;
  } tbl_req_t;

endpackage

[hdl/arwat_item_if.sv]
`timescale 1ns / 1ps

interface arwat_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  accel;
  logic [4:0]  slot;
  logic        entry_valid;
  logic [15:0] byte_offset;
  logic [63:0] data;
  logic [63:0] phys_base;

  modport source (
    output valid, kind, accel, slot, entry_valid, byte_offset, data, phys_base,
    input  ready
  );
  modport sink (
    input  valid, kind, accel, slot, entry_valid, byte_offset, data, phys_base,
    output ready
  );
endinterface

[hdl/arwat_result_if.sv]
`timescale 1ns / 1ps

interface arwat_result_if;
  logic        valid;
  logic        ready;
  logic [19:0] bus_address;
  logic [31:0] write_word;
  logic        last;

  modport source (
    output valid, bus_address, write_word, last,
    input  ready
  );
  modport sink (
    input  valid, bus_address, write_word, last,
    output ready
  );
endinterface

[hdl/arwat_cfg_if.sv]
`timescale 1ns / 1ps

interface arwat_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] window_count;

  modport source (
    output valid, window_count,
    input  ready
  );
  modport sink (
    input  valid, window_count,
    output ready
  );
endinterface

[hdl/arwat_tables.sv]
`timescale 1ns / 1ps

module arwat_tables #(
  parameter int NE = 192,
  parameter int EW = 8,
  parameter int NW = 16,
  parameter int WW = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  arwat_pkg::tbl_req_t          req,
  input  logic [EW-1:0]                ent_wr_idx,
  input  logic                         ent_wr_valid,
  input  logic [15:0]                  ent_wr_offset,
  input  logic [WW-1:0]                win_wr_idx,
  input  logic [arwat_pkg::TAG_W-1:0]  win_wr_tag,
  input  logic [63:0]                  win_wr_phys,
  input  logic [EW-1:0]                ent_rd_idx,
  input  logic [WW-1:0]                win_rd_idx,
  output logic                         ent_rd_valid,
  output logic [15:0]                  ent_rd_offset,
  output logic [arwat_pkg::TAG_W-1:0]  win_rd_tag,
  output logic [63:0]                  win_rd_phys
);

  logic [NE-1:0] ent_vld;
  logic [15:0]   ent_mem [NE];
  logic [arwat_pkg::TAG_W-1:0] tag_mem [NW];
  logic [63:0]   phys_mem [NW];

  // valid marks clear on reset, offsets stay undefined until loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (req.ld_reg) begin
      ent_vld[ent_wr_idx] <= ent_wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ld_reg) begin
      ent_mem[ent_wr_idx] <= ent_wr_offset;
    end
    if (req.rd_reg) begin
      ent_rd_offset <= ent_mem[ent_rd_idx];
      ent_rd_valid  <= ent_vld[ent_rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (req.ld_win) begin
      tag_mem[win_wr_idx]  <= win_wr_tag;
      phys_mem[win_wr_idx] <= win_wr_phys;
    end
    if (req.rd_win) begin
      win_rd_tag  <= tag_mem[win_rd_idx];
      win_rd_phys <= phys_mem[win_rd_idx];
    end
  end

endmodule

[hdl/accel_reg_write_address_translator_top.sv]
`timescale 1ns / 1ps

// Translates register writes aimed at accelerators. Load requests fill the
// per-accelerator address-register table and the translation windows as
// they are accepted. A write request first scans its accelerator's ADDR_REGS
// table entries, one per cycle through a single read port, then (only when
// the offset is an address register) scans the first window_count windows,
// at most WINDOWS, one per cycle. A plain register write yields one bus
// write; an address-register write yields a low and a high word at offset
// and offset+4, or nothing on a window miss. The request side is ready only
// while the sequencer is idle; the output register lets the next request in
// while the last write still waits for the bus. window_count may only be
// written while the block is idle.
module accel_reg_write_address_translator_top #(
  parameter int NUM_ACCELS = 8,
  parameter int ADDR_REGS  = 24,
  parameter int WINDOWS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  arwat_cfg_if.sink         cfg,
  arwat_item_if.sink        item,
  arwat_result_if.source    result
);

  // table sizes and index widths
  localparam int NE     = NUM_ACCELS * ADDR_REGS;
  localparam int EW     = (NE > 1) ? $clog2(NE) : 1;
  localparam int WW     = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int SCAN_N = (WINDOWS > ADDR_REGS) ? WINDOWS : ADDR_REGS;
  localparam int CW     = $clog2(SCAN_N + 1);

  arwat_pkg::state_t   state, state_next;
  arwat_pkg::tbl_req_t tbl_req;

  logic [4:0]       window_count;
  logic [CW-1:0]    cnt;        // next entry to read
  logic [CW-1:0]    limit;      // windows searched for this request
  logic             pend;       // read data of the last issued entry is back
  logic [EW-1:0]    ent_base;
  logic [15:0]      offset;
  logic [63:0]      data;
  logic [19:0]      addr;
  logic [63:0]      sum;

  logic             ent_rd_valid;
  logic [15:0]      ent_rd_offset;
  logic [arwat_pkg::TAG_W-1:0] win_rd_tag;
  logic [63:0]      win_rd_phys;

  logic accept, is_write, reg_hit, win_hit, reg_end, win_end, out_free, load_out;
  logic issue_reg, issue_win;

  // config register, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
    end else if (cfg.valid) begin
      window_count <= cfg.window_count;
    end
  end

  assign accept   = item.valid && item.ready;
  assign is_write = (item.kind == arwat_pkg::KIND_WRITE) &&
                    (32'(item.accel) < NUM_ACCELS);

  // compare the entry read in the previous cycle
  assign reg_hit  = (state == arwat_pkg::ST_SCAN_REG) && pend && ent_rd_valid &&
                    (ent_rd_offset == offset);
  assign win_hit  = (state == arwat_pkg::ST_SCAN_WIN) && pend &&
                    (win_rd_tag == data[63:arwat_pkg::TAG_LSB]);
  assign reg_end  = !pend && (cnt == CW'(ADDR_REGS));
  assign win_end  = !pend && (cnt == limit);
  assign out_free = !result.valid || result.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      arwat_pkg::ST_IDLE: begin
        if (accept && is_write) begin
          state_next = arwat_pkg::ST_SCAN_REG;
        end
      end
      arwat_pkg::ST_SCAN_REG: begin
        if (reg_hit) begin
          state_next = arwat_pkg::ST_SCAN_WIN;
        end else if (reg_end) begin
          state_next = arwat_pkg::ST_EMIT_ONE;
        end
      end
      arwat_pkg::ST_SCAN_WIN: begin
        if (win_hit) begin
          state_next = arwat_pkg::ST_EMIT_LO;
        end else if (win_end) begin
          state_next = arwat_pkg::ST_IDLE;   // miss: nothing written
        end
      end
      arwat_pkg::ST_EMIT_ONE: begin
        if (out_free) begin
          state_next = arwat_pkg::ST_IDLE;
        end
      end
      arwat_pkg::ST_EMIT_LO: begin
        if (out_free) begin
          state_next = arwat_pkg::ST_EMIT_HI;
        end
      end
      arwat_pkg::ST_EMIT_HI: begin
        if (out_free) begin
          state_next = arwat_pkg::ST_IDLE;
        end
      end
      default: state_next = arwat_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item.ready     = (state == arwat_pkg::ST_IDLE);
    issue_reg      = (state == arwat_pkg::ST_SCAN_REG) && !reg_hit &&
                     (cnt < CW'(ADDR_REGS));
    issue_win      = (state == arwat_pkg::ST_SCAN_WIN) && !win_hit && (cnt < limit);
    load_out       = out_free && ((state == arwat_pkg::ST_EMIT_ONE) ||
                                  (state == arwat_pkg::ST_EMIT_LO) ||
                                  (state == arwat_pkg::ST_EMIT_HI));
    tbl_req.ld_reg = accept && (item.kind == arwat_pkg::KIND_LOAD_REG) &&
                     (32'(item.accel) < NUM_ACCELS) && (32'(item.slot) < ADDR_REGS);
    tbl_req.ld_win = accept && (item.kind == arwat_pkg::KIND_LOAD_WIN) &&
                     (32'(item.slot) < WINDOWS);
    tbl_req.rd_reg = issue_reg;
    tbl_req.rd_win = issue_win;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arwat_pkg::ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue_reg || issue_win;
    end
  end

  // request capture and scan counter
  always_ff @(posedge clk) begin
    if (accept) begin
      offset   <= item.byte_offset;
      data     <= item.data;
      addr     <= arwat_pkg::ACCEL_BASE[item.accel] + 20'(item.byte_offset);
      ent_base <= EW'(32'(item.accel) * ADDR_REGS);
      limit    <= (32'(window_count) > WINDOWS) ? CW'(WINDOWS) : CW'(window_count);
      cnt      <= '0;
    end else if (reg_hit) begin
      cnt      <= '0;   // restart the counter for the window scan
    end else if (issue_reg || issue_win) begin
      cnt      <= cnt + 1'b1;
    end
    // full 64-bit translated value
    if (win_hit) begin
      sum <= win_rd_phys + (data & arwat_pkg::LOW_MASK);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      case (state)
        arwat_pkg::ST_EMIT_LO: begin
          result.bus_address <= addr;
          result.write_word  <= sum[31:0];
          result.last        <= 1'b0;
        end
        arwat_pkg::ST_EMIT_HI: begin
          result.bus_address <= addr + 20'd4;
          result.write_word  <= sum[63:32];
          result.last        <= 1'b1;
        end
        default: begin
          // plain register write: low data word only
          result.bus_address <= addr;
          result.write_word  <= data[31:0];
          result.last        <= 1'b1;
        end
      endcase
    end
  end

  arwat_tables #(
    .NE (NE),
    .EW (EW),
    .NW (WINDOWS),
    .WW (WW)
  ) u_tables (
    .clk           (clk),
    .rst           (rst),
    .req           (tbl_req),
    .ent_wr_idx    (EW'(32'(item.accel) * ADDR_REGS + 32'(item.slot))),
    .ent_wr_valid  (item.entry_valid),
    .ent_wr_offset (item.byte_offset),
    .win_wr_idx    (WW'(item.slot)),
    .win_wr_tag    (item.data[63:arwat_pkg::TAG_LSB]),
    .win_wr_phys   (item.phys_base),
    .ent_rd_idx    (ent_base + EW'(cnt)),
    .win_rd_idx    (cnt[WW-1:0]),
    .ent_rd_valid  (ent_rd_valid),
    .ent_rd_offset (ent_rd_offset),
    .win_rd_tag    (win_rd_tag),
    .win_rd_phys   (win_rd_phys)
  );

endmodule

[tb/sv/arwat_write_checker.sv]
`timescale 1ns / 1ps

module arwat_write_checker
  import arwat_pkg::*;
#(
  parameter int NUM_ACCELS = 8,
  parameter int ADDR_REGS  = 24,
  parameter int WINDOWS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  arwat_cfg_if        cfg,
  arwat_item_if       req,
  arwat_result_if     bus,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [BUS_W-1:0] addr;
    logic [31:0]      word;
    logic             last;
  } bus_write_t;

  logic [15:0]      off_tbl  [NUM_ACCELS*ADDR_REGS];
  bit               vld_tbl  [NUM_ACCELS*ADDR_REGS];
  logic [TAG_W-1:0] tag_tbl  [WINDOWS];
  logic [63:0]      phys_tbl [WINDOWS];
  logic [4:0]       win_count;
  bus_write_t       pending_writes [$];
  int unsigned      err_cnt = 0;

  function automatic void push_write(input logic [BUS_W-1:0] addr, input logic [31:0] word,
                                     input logic last);
    bus_write_t bw;
    bw.addr = addr;
    bw.word = word;
    bw.last = last;
    pending_writes.push_back(bw);
  endfunction

  // table updates and bus writes caused by one accepted request
  function automatic void predict_request();
    int               base_idx;
    int               n;
    logic [BUS_W-1:0] addr;
    logic [63:0]      xlat;
    bit               is_areg;
    bit               hit;
    case (req.kind)
      KIND_LOAD_REG: begin
        if (req.accel < NUM_ACCELS && req.slot < ADDR_REGS) begin
          off_tbl[req.accel*ADDR_REGS + req.slot] = req.byte_offset;
          vld_tbl[req.accel*ADDR_REGS + req.slot] = req.entry_valid;
        end
      end
      KIND_LOAD_WIN: begin
        if (req.slot < WINDOWS) begin
          tag_tbl[req.slot]  = req.data[63:TAG_LSB];
          phys_tbl[req.slot] = req.phys_base;
        end
      end
      KIND_WRITE: begin
        if (req.accel < NUM_ACCELS) begin
          addr     = ACCEL_BASE[req.accel] + BUS_W'(req.byte_offset);
          base_idx = req.accel * ADDR_REGS;
          is_areg  = 1'b0;
          for (int j = 0; j < ADDR_REGS; j++)
            if (vld_tbl[base_idx+j] && off_tbl[base_idx+j] == req.byte_offset) is_areg = 1'b1;
          if (!is_areg) begin
            push_write(addr, req.data[31:0], 1'b1);
          end else begin
            n   = (win_count > WINDOWS) ? WINDOWS : win_count;
            hit = 1'b0;
            for (int w = 0; w < n; w++) begin
              if (!hit && tag_tbl[w] == req.data[63:TAG_LSB]) begin
                hit  = 1'b1;
                xlat = phys_tbl[w] + (req.data & LOW_MASK);
                push_write(addr, xlat[31:0], 1'b0);
                push_write(addr + 20'd4, xlat[63:32], 1'b1);
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_write();
    bus_write_t got;
    bus_write_t want;
    got.addr = bus.bus_address;
    got.word = bus.write_word;
    got.last = bus.last;
    if (pending_writes.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("unexpected bus write: addr %h word %h last %b", got.addr, got.word, got.last);
    end else begin
      want = pending_writes.pop_front();
      if (got.addr !== want.addr || got.word !== want.word || got.last !== want.last) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("bus write mismatch: expected addr %h word %h last %b, got addr %h word %h last %b",
                   want.addr, want.word, want.last, got.addr, got.word, got.last);
      end
    end
  endfunction

  // output side first: a write can never belong to the request taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      foreach (vld_tbl[i]) vld_tbl[i] = 1'b0;
      win_count = '0;
      pending_writes.delete();
    end else begin
      if (bus.valid && bus.ready) check_write();
      if (cfg.valid && cfg.ready) win_count = cfg.window_count;
      if (req.valid && req.ready) predict_request();
    end
    mismatches  <= err_cnt;
    outstanding <= pending_writes.size();
  end

endmodule

[tb/sv/accel_reg_write_address_translator_top_tb.sv]
`timescale 1ns / 1ps

module accel_reg_write_address_translator_top_tb;
  import arwat_pkg::*;

  localparam int N_ACCEL = 8;
  localparam int N_REGS  = 24;
  localparam int N_WIN   = 16;

  // kind value the block must drop
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // misses and loads give no write
  localparam int DRAIN       = 60;
  localparam int SEG_ITEMS   = 160;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_cnt = 0;

  // idling percentages of the current phase
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // what has been loaded, so that random requests can aim at real entries
  logic [15:0]      shadow_off [N_ACCEL][N_REGS];
  bit               shadow_vld [N_ACCEL][N_REGS];
  logic [TAG_W-1:0] shadow_tag [N_WIN];

  // window counts per random segment: the extremes, saturation and in-between
  int wc_plan [8] = '{16, 3, 31, 0, 17, 8, 16, 16};

  arwat_cfg_if    cfg_ch ();
  arwat_item_if   req_ch ();
  arwat_result_if bus_ch ();

  accel_reg_write_address_translator_top #(
    .NUM_ACCELS (N_ACCEL),
    .ADDR_REGS  (N_REGS),
    .WINDOWS    (N_WIN)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (req_ch),
    .result (bus_ch)
  );

  // predicts the bus writes and compares them as they come out
  arwat_write_checker #(
    .NUM_ACCELS (N_ACCEL),
    .ADDR_REGS  (N_REGS),
    .WINDOWS    (N_WIN)
  ) write_check (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .req         (req_ch),
    .bus         (bus_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  // bus side back-pressure, random per cycle at the phase's rate
  always @(posedge clk) begin
    bus_ch.ready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one request; valid is left high so back-to-back requests need no extra step
  task automatic send_item(input logic [1:0] kind, input logic [2:0] accel,
                           input logic [4:0] slot, input logic ev,
                           input logic [15:0] off, input logic [63:0] data,
                           input logic [63:0] phys);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= kind;
    req_ch.accel       <= accel;
    req_ch.slot        <= slot;
    req_ch.entry_valid <= ev;
    req_ch.byte_offset <= off;
    req_ch.data        <= data;
    req_ch.phys_base   <= phys;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // keep the stimulus view of the tables in step
    if (kind == KIND_LOAD_REG && slot < N_REGS) begin
      shadow_off[accel][slot] = off;
      shadow_vld[accel][slot] = ev;
    end
    if (kind == KIND_LOAD_WIN && slot < N_WIN) shadow_tag[slot] = data[63:TAG_LSB];
  endtask

  task automatic load_reg(input logic [2:0] accel, input logic [4:0] slot, input logic ev,
                          input logic [15:0] off);
    send_item(KIND_LOAD_REG, accel, slot, ev, off, {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic load_win(input logic [4:0] slot, input logic [63:0] vaddr,
                          input logic [63:0] phys);
    send_item(KIND_LOAD_WIN, 3'($urandom), slot, 1'($urandom), 16'($urandom), vaddr, phys);
  endtask

  task automatic reg_write(input logic [2:0] accel, input logic [15:0] off,
                           input logic [63:0] data);
    send_item(KIND_WRITE, accel, 5'($urandom), 1'($urandom), off, data, {$urandom, $urandom});
  endtask

  // hold off until every expected write is out and the sequencer has gone idle
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_window_count(input logic [4:0] count);
    settle();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.window_count <= count;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_request();
    int          r;
    int          a;
    int          j;
    int          w;
    int          tries;
    logic [15:0] off;
    logic [63:0] d;
    r = $urandom_range(0, 99);
    a = $urandom_range(0, N_ACCEL-1);
    if (r < 60) begin
      // address-register write, mostly tagged with a loaded window
      j     = $urandom_range(0, N_REGS-1);
      tries = 0;
      while (!shadow_vld[a][j] && tries < 8) begin
        j = $urandom_range(0, N_REGS-1);
        tries++;
      end
      off = shadow_vld[a][j] ? shadow_off[a][j] : 16'($urandom);
      if ($urandom_range(0, 9) < 8) begin
        w = $urandom_range(0, N_WIN-1);
        d = {shadow_tag[w], 30'($urandom)};
      end else begin
        d = {$urandom, $urandom};
      end
      reg_write(3'(a), off, d);
    end else if (r < 80) begin
      // plain write: small aligned offsets may still hit a table entry
      off = ($urandom_range(0, 1) == 0) ? 16'(4 * $urandom_range(0, 255)) : 16'($urandom);
      reg_write(3'(a), off, {$urandom, $urandom});
    end else if (r < 90) begin
      // entry load, slots past the table now and then
      load_reg(3'(a), 5'($urandom_range(0, 31)), $urandom_range(0, 3) != 0,
               ($urandom_range(0, 3) != 0) ? 16'(4 * $urandom_range(0, 255)) : 16'($urandom));
    end else if (r < 97) begin
      // window load, reusing a live tag half the time to get duplicates
      w = $urandom_range(0, N_WIN-1);
      d = ($urandom_range(0, 1) == 0) ? {shadow_tag[w], 30'($urandom)} : {$urandom, $urandom};
      load_win(5'($urandom_range(0, 19)), d, {$urandom, $urandom});
    end else begin
      send_item(KIND_UNUSED, 3'(a), 5'($urandom), 1'($urandom), 16'($urandom),
                {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.kind         = KIND_WRITE;
    req_ch.accel        = '0;
    req_ch.slot         = '0;
    req_ch.entry_valid  = 1'b0;
    req_ch.byte_offset  = '0;
    req_ch.data         = '0;
    req_ch.phys_base    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.window_count = '0;
    bus_ch.ready        = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // fill both tables so no scan ever touches an entry that was never loaded
    for (int a = 0; a < N_ACCEL; a++)
      for (int s = 0; s < N_REGS; s++)
        load_reg(3'(a), 5'(s), $urandom_range(0, 3) != 0, 16'(4 * $urandom_range(0, 255)));
    for (int w = 0; w < N_WIN; w++) load_win(5'(w), {$urandom, $urandom}, {$urandom, $urandom});

    // directed requests
    set_window_count(5'd16);
    load_reg(3'd2, 5'd0, 1'b1, 16'hFFFC);
    // all-ones base: the sum carries out of 64 bits, high-word address wraps to zero
    load_win(5'd0, {34'h2_AAAA_5555, 30'h0}, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(3'd2, 16'hFFFC, {34'h2_AAAA_5555, 30'h3FFF_FFFF});
    // same tag in two windows: the lower one wins; carry through bits 30 to 33
    load_win(5'd1, {34'h1_2345_6789, 30'h0}, 64'h0000_0003_FFFF_FFFF);
    load_win(5'd3, {34'h1_2345_6789, 30'h0}, 64'h5555_0000_0000_0000);
    reg_write(3'd2, 16'hFFFC, {34'h1_2345_6789, 30'h0000_0001});
    // zero tag and zero data
    load_win(5'd2, 64'h0, 64'h0);
    reg_write(3'd2, 16'hFFFC, 64'h0);
    // window miss gives nothing
    reg_write(3'd2, 16'hFFFC, 64'hFFFF_FFFF_FFFF_FFFF);
    // entry stored with its valid mark clear
    load_reg(3'd2, 5'd1, 1'b0, 16'h0010);
    reg_write(3'd2, 16'h0010, 64'h0123_4567_89AB_CDEF);
    // plain writes at the offset extremes
    reg_write(3'd0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(3'd7, 16'h0000, 64'h0);
    // loads past the end of either table are dropped, so is the unused kind
    load_reg(3'd5, 5'd24, 1'b1, 16'h0040);
    load_reg(3'd5, 5'd31, 1'b1, 16'h0044);
    load_win(5'd16, 64'h0, 64'h0);
    load_win(5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_UNUSED, 3'h7, 5'h1F, 1'b1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF);
    // a count above the window total searches all windows
    load_win(5'd15, {34'h3_0F0F_F0F0, 30'h0}, 64'h8000_0000_0000_0000);
    set_window_count(5'd31);
    reg_write(3'd2, 16'hFFFC, {34'h3_0F0F_F0F0, 30'h1555_5555});
    // with one window only slot zero is searched
    set_window_count(5'd1);
    reg_write(3'd2, 16'hFFFC, {34'h1_2345_6789, 30'h0});
    reg_write(3'd2, 16'hFFFC, {34'h2_AAAA_5555, 30'h0});

    // random segments, each with its own window count and idling mix
    for (int seg = 0; seg < 8; seg++) begin
      set_window_count(5'(wc_plan[seg]));
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      repeat (SEG_ITEMS) random_request();
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
